@@ rtl/core/hrem_pkg.sv @@
// package for the reprojection error mean block: widths, register indexes, types
`default_nettype none
package hrem_pkg;
	localparam int HW = 48;
	localparam int CW = 16;
	localparam int CNTW = 11;
	localparam int MAX_PAIRS = 1024;
	localparam int NREG = 8;
	localparam int IDXW = 3;

	typedef enum logic [IDXW-1:0] {
		REG_XX = 3'd0, REG_XY = 3'd1, REG_XT = 3'd2, REG_YX = 3'd3,
		REG_YY = 3'd4, REG_YT = 3'd5, REG_WX = 3'd6, REG_WY = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] src_x;
		logic signed [CW-1:0] src_y;
		logic signed [CW-1:0] dst_x;
		logic signed [CW-1:0] dst_y;
		logic                 last_pair;
	} pair_t;

	typedef struct packed {
		logic [HW-1:0]   mean_error;
		logic [CNTW-1:0] pairs_used;
		logic            bad_flag;
	} result_t;
endpackage
`default_nettype wire

@@ rtl/core/hrem_if.sv @@
// valid/ready channel interface carrying one payload
`default_nettype none
interface hrem_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/homography_reproj_error_mean.sv @@
// Mean squared reprojection error of matched point pairs under a homography.
// in: hrem_if sink of pair_t (src/dst Q11.4, last_pair); out: hrem_if source
// of result_t (mean_error Q40.8, pairs_used, bad_flag), one transaction per
// set, on the pair marked last. Configuration: cfg_we/cfg_idx/cfg_data write the
// eight Q15.32 terms; write them only while idle, which the block does not check.
// Each pair passes through six signed products by a shared 48x4 digit
// multiplier, then for each of two projective quotients a setup state and a
// one-bit-per-cycle restoring divider that stops early once the quotient
// caps, then a distance state, two bit-serial squares, an accumulate state
// and the return to idle. A zero denominator skips the quotients and squares
// and accumulates a saturated error with the flag set. The final pair adds a
// 64-step mean division, a rounding state and the output register. A new
// pair is accepted only in idle, once the previous one is done. The result
// sits in an output register, so a stalled receiver holds the block only
// once the next result is ready.
// Reset restores the identity homography and clears sum, count and flag.
`default_nettype none
module homography_reproj_error_mean (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [hrem_pkg::IDXW-1:0] cfg_idx,
	input  wire logic [hrem_pkg::HW-1:0]   cfg_data,
	hrem_if.sink                       in_ch,
	hrem_if.source                     out_ch
);
	import hrem_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001, S_MUL = 10'b0000000010, S_DIVSET = 10'b0000000100,
		S_DIV = 10'b0000001000, S_DIST = 10'b0000010000, S_SQ = 10'b0000100000,
		S_ACC = 10'b0001000000, S_MDIV = 10'b0010000000, S_MFIN = 10'b0100000000,
		S_OUT = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [HW-1:0] h_q [NREG];
	pair_t pr_q;
	logic [2:0] term_q;
	logic [3:0] dig_q;
	logic signed [67:0] acc_q, nx_q, ny_q, w_q;
	logic div_y_q;
	logic [7:0] dstep_q;
	logic [63:0] rem_q;
	logic [63:0] num_q;
	logic [41:0] quo_q;
	logic [63:0] den_q;
	logic neg_q;
	logic signed [47:0] px_q, py_q;
	logic [63:0] sq_q, err_q;
	logic [5:0] sstep_q;
	logic [63:0] sq_a_q;
	logic sq_y_q;
	logic [63:0] sum_q;
	logic [CNTW-1:0] cnt_q;
	logic fault_q;
	logic res_valid_q;
	result_t res_q;
	logic [6:0] mstep_q;

	// operand selection for the digit multiplier
	logic signed [HW-1:0] hsel;
	logic signed [CW-1:0] csel;
	always_comb begin
		hsel = $signed(h_q[term_q]);
		case (term_q) inside
			REG_XX, REG_YX, REG_WX: csel = pr_q.src_x;
			default: csel = pr_q.src_y;
		endcase
	end
	logic [3:0] digit;
	assign digit = csel[dig_q*4 +: 4];
	logic signed [67:0] part;
	always_comb begin
		if (dig_q == 4'd3)
			part = $signed({{20{hsel[HW-1]}}, hsel}) * $signed(digit) <<< 12;
		else
			part = $signed({{20{hsel[HW-1]}}, hsel}) * $signed({1'b0, digit}) <<< (dig_q*4);
	end
	logic signed [67:0] prod_full, prod_fl;
	assign prod_full = acc_q + part;
	assign prod_fl = prod_full >>> 4;

	// numerators with the translation terms
	logic signed [67:0] nxt, nyt;
	assign nxt = nx_q + $signed({{20{h_q[REG_XT][HW-1]}}, h_q[REG_XT]});
	assign nyt = ny_q + $signed({{20{h_q[REG_YT][HW-1]}}, h_q[REG_YT]});

	// divider subtract step
	logic [64:0] rtry;
	assign rtry = {rem_q, num_q[63]} - {1'b0, den_q};
	logic [41:0] quo_sat;
	assign quo_sat = (quo_q >= 42'(64'd1 << 40)) ? 42'(64'd1 << 40) : quo_q;

	logic signed [68:0] dxf, dyf;
	assign dxf = $signed({{21{px_q[47]}}, px_q}) - ($signed({{53{pr_q.dst_x[CW-1]}}, pr_q.dst_x}) <<< 4);
	assign dyf = $signed({{21{py_q[47]}}, py_q}) - ($signed({{53{pr_q.dst_y[CW-1]}}, pr_q.dst_y}) <<< 4);

	logic [64:0] sum_add;
	assign sum_add = {1'b0, sum_q} + {1'b0, err_q};

	logic [63:0] mrtry;
	assign mrtry = {rem_q[62:0], num_q[63]} - {53'b0, cnt_q};

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = res_valid_q;
	assign out_ch.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= 48'h0001_0000_0000; h_q[1] <= '0; h_q[2] <= '0; h_q[3] <= '0;
			h_q[4] <= 48'h0001_0000_0000; h_q[5] <= '0; h_q[6] <= '0; h_q[7] <= '0;
		end else if (cfg_we) begin
			h_q[cfg_idx] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q <= '0;
			cnt_q <= '0;
			fault_q <= 1'b0;
			res_valid_q <= 1'b0;
			pr_q <= '0;
			term_q <= REG_XX;
			dig_q <= '0;
			acc_q <= '0;
			nx_q <= '0;
			ny_q <= '0;
			w_q <= '0;
			div_y_q <= 1'b0;
			dstep_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			neg_q <= 1'b0;
			px_q <= '0;
			py_q <= '0;
			sq_q <= '0;
			err_q <= '0;
			sstep_q <= '0;
			sq_a_q <= '0;
			sq_y_q <= 1'b0;
			res_q <= '0;
			mstep_q <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						pr_q <= in_ch.data;
						term_q <= REG_XX;
						dig_q <= 4'd0;
						acc_q <= '0;
						nx_q <= '0; ny_q <= '0; w_q <= 68'sd4294967296;
						if (32'(cnt_q) >= MAX_PAIRS) begin
							fault_q <= 1'b1;
							state_q <= in_ch.data.last_pair ? S_MDIV : S_IDLE;
							num_q <= sum_q; rem_q <= '0; mstep_q <= '0;
						end else
							state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (dig_q == 4'd3) begin
						acc_q <= '0;
						dig_q <= 4'd0;
						case (term_q) inside
							REG_XX, REG_XY: nx_q <= nx_q + prod_fl;
							REG_YX, REG_YY: ny_q <= ny_q + prod_fl;
							default: w_q <= w_q + prod_fl;
						endcase
						if (term_q == REG_XY) term_q <= REG_YX;
						else if (term_q == REG_YY) term_q <= REG_WX;
						else if (term_q == REG_WY) begin
							state_q <= S_DIVSET;
							div_y_q <= 1'b0;
						end else term_q <= term_q + 3'd1;
					end else begin
						acc_q <= prod_full;
						dig_q <= dig_q + 4'd1;
					end
				end
				S_DIVSET: begin
					if (term_q == REG_WY && w_q == 0) begin
						err_q <= 64'hFFFF_FFFF_FFFF;
						fault_q <= 1'b1;
						state_q <= S_ACC;
					end else begin
						if (!div_y_q) begin
							num_q <= 64'(nxt[67] ? -nxt : nxt);
							neg_q <= nxt[67] ^ w_q[67];
						end else begin
							num_q <= 64'(nyt[67] ? -nyt : nyt);
							neg_q <= nyt[67] ^ w_q[67];
						end
						den_q <= 64'(w_q[67] ? -w_q : w_q);
						rem_q <= '0;
						quo_q <= '0;
						dstep_q <= '0;
						term_q <= REG_XX;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (quo_q >= 42'(64'd1 << 40)) begin
						quo_q <= 42'(64'd1 << 40);
						dstep_q <= 8'd73;
					end else begin
						num_q <= {num_q[62:0], 1'b0};
						if (!rtry[64]) begin
							rem_q <= rtry[63:0];
							quo_q <= {quo_q[40:0], 1'b1};
						end else begin
							rem_q <= {rem_q[62:0], num_q[63]};
							quo_q <= {quo_q[40:0], 1'b0};
						end
						dstep_q <= dstep_q + 8'd1;
					end
					if (dstep_q == 8'd73) begin
						if (!div_y_q) begin
							px_q <= neg_q ? -48'(({1'b0, quo_sat} + 43'd1) >> 1)
								: 48'(({1'b0, quo_sat} + 43'd1) >> 1);
							div_y_q <= 1'b1;
							term_q <= REG_WY;
							state_q <= S_DIVSET;
						end else begin
							py_q <= neg_q ? -48'(({1'b0, quo_sat} + 43'd1) >> 1)
								: 48'(({1'b0, quo_sat} + 43'd1) >> 1);
							state_q <= S_DIST;
						end
					end
				end
				S_DIST: begin
					if (dxf <= -69'sd4294967296 || dxf >= 69'sd4294967296 ||
						dyf <= -69'sd4294967296 || dyf >= 69'sd4294967296) begin
						err_q <= 64'hFFFF_FFFF_FFFF;
						fault_q <= 1'b1;
						state_q <= S_ACC;
					end else begin
						sq_a_q <= 64'(dxf[68] ? -dxf : dxf);
						num_q <= 64'(dyf[68] ? -dyf : dyf);
						sq_q <= '0;
						err_q <= '0;
						sstep_q <= '0;
						sq_y_q <= 1'b0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (sstep_q == 6'd32) begin
						err_q <= err_q + (sq_q >> 8);
						sq_q <= '0;
						sstep_q <= '0;
						sq_a_q <= num_q;
						sq_y_q <= 1'b1;
						if (sq_y_q) state_q <= S_ACC;
					end else begin
						sq_q <= sq_q + (sq_a_q[sstep_q] ? (sq_a_q << sstep_q) : 64'd0);
						sstep_q <= sstep_q + 6'd1;
					end
				end
				S_ACC: begin
					if (sum_add[64]) begin
						sum_q <= '1;
						fault_q <= 1'b1;
					end else sum_q <= sum_add[63:0];
					cnt_q <= cnt_q + 1'b1;
					if (pr_q.last_pair) begin
						num_q <= sum_add[64] ? '1 : sum_add[63:0];
						rem_q <= '0;
						mstep_q <= '0;
						state_q <= S_MDIV;
					end else state_q <= S_IDLE;
				end
				S_MDIV: begin
					num_q <= {num_q[62:0], 1'b0};
					if (cnt_q == 0) begin
						quo_q <= '0;
						sq_q <= num_q;
						rem_q <= '0;
					end else if ({rem_q[62:0], num_q[63]} >= {53'b0, cnt_q} || rem_q[63]) begin
						rem_q <= mrtry;
						sq_q <= {sq_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], num_q[63]};
						sq_q <= {sq_q[62:0], 1'b0};
					end
					mstep_q <= mstep_q + 7'd1;
					if (mstep_q == 7'd63 || cnt_q == 0) state_q <= S_MFIN;
				end
				S_MFIN: begin
					if (cnt_q != 0 && ({rem_q, 1'b0} >= {53'b0, cnt_q})) sq_q <= sq_q + 64'd1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid_q) begin
						res_q.mean_error <= (sq_q > 64'hFFFF_FFFF_FFFF) ? '1 : sq_q[HW-1:0];
						res_q.pairs_used <= cnt_q;
						res_q.bad_flag <= fault_q || (sq_q > 64'hFFFF_FFFF_FFFF);
						res_valid_q <= 1'b1;
						sum_q <= '0;
						cnt_q <= '0;
						fault_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/hrem_chk.sv @@
// port-level checker for the reprojection error mean block, with its bind
`default_nettype none
module hrem_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [10:0] out_pairs
);
	import hrem_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_pairs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pairs)) else $error("count changed in stall");
	a_pairs_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_pairs != 11'd0 && out_pairs <= CNTW'(MAX_PAIRS))
		else $error("bad count");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_ready, out_valid})) else $error("unknown handshake");
endmodule

bind homography_reproj_error_mean hrem_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_pairs(out_ch.data.pairs_used)
);
`default_nettype wire
